// ===== rtl/core/slom_pkg.sv =====
// Shared codes for the skip-list ordered map: opcodes, result status codes
// and the sequencer state type. No dependencies.
package slom_pkg;

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LREQ,
      S_LDAT,
      S_KDAT,
      S_DISP,
      S_VDAT,
      S_FDAT,
      S_ILREQ,
      S_ILDAT,
      S_ISET,
      S_DHDAT,
      S_DLREQ,
      S_DLDAT,
      S_DCREQ,
      S_DCDAT,
      S_DCLR,
      S_PUSH
   } state_type;

endpackage

// ===== rtl/core/slom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for every node store of the skip-list map; no dependencies.
module slom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/core/skip_list_ordered_map.sv =====
// Skip-list ordered map: top level with the request sequencer and node stores.
// Depends on slom_pkg and slom_ram.
// Search reads one link-RAM and one key-RAM word per hop; insert adds a link read and two link
// writes per level joined; delete a height read, then per level a read, optional bypass, clear.
// Throughput: one request at a time; busy is high until the result strobe.
// Reset is synchronous: header links null, all nodes free, no clearing pass.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
module skip_list_ordered_map
   import slom_pkg::*;
#(
   parameter int MAX_LEVELS = 16,
   parameter int POOL_NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_lookup_key,
   input  logic [63:0] req_value_in,
   input  logic [4:0]  req_node_height,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_value_out
);

   localparam int IW   = $clog2(POOL_NODES);
   localparam int CW   = $clog2(POOL_NODES + 2);
   localparam int CNTW = $clog2(POOL_NODES + 1);
   localparam int LVW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int HW   = $clog2(MAX_LEVELS + 1);
   localparam int AW   = $clog2(POOL_NODES * MAX_LEVELS);
   localparam int LD   = POOL_NODES * MAX_LEVELS;
   localparam logic [CW-1:0] NIL = CW'(POOL_NODES);
   localparam logic [CW-1:0] HDR = CW'(POOL_NODES + 1);

   state_type state_ff, state_in;
   logic [CW-1:0]   x_ff, x_in, nxt_ff, nxt_in, cand_ff, cand_in;
   logic [LVW-1:0]  lvl_ff, lvl_in, i_ff, i_in;
   logic [CNTW-1:0] hops_ff, hops_in, fc_ff, fc_in, min_ff, min_in;
   logic            hit_ff, hit_in;
   logic [1:0]      op_ff, op_in;
   logic [31:0]     key_ff, key_in;
   logic [63:0]     val_ff, val_in;
   logic [HW-1:0]   h_ff, h_in;
   logic [IW-1:0]   n_ff, n_in;
   logic [CW-1:0]   hdr_ff [MAX_LEVELS];
   logic [CW-1:0]   pred_ff [MAX_LEVELS];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [63:0]     rsp_value_ff, rsp_value_in;

   logic            hdr_we;
   logic [CW-1:0]   hdr_wd;
   logic            pred_we;
   logic [LVW-1:0]  rd_lvl;
   logic [CW-1:0]   hdr_rd, pred_rd;

   logic            lk_we;
   logic [IW-1:0]   lw_node, lr_node;
   logic [LVW-1:0]  lw_lvl, lr_lvl;
   logic [CW-1:0]   lw_data, link_rdata;
   logic [AW-1:0]   link_waddr, link_raddr;

   logic            key_we, val_we, ht_we, stk_we;
   logic [IW-1:0]   key_raddr, val_waddr, val_raddr, stk_addr, node_w;
   logic [31:0]     key_rdata;
   logic [63:0]     val_wdata, val_rdata;
   logic [HW-1:0]   ht_rdata;
   logic [IW-1:0]   stk_rdata;

   logic [5:0]      hx;
   logic            last_lvl, key_lt, key_eq;
   logic [CW-1:0]   got;
   logic [CNTW-1:0] pop_idx;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

   // key compare unit, signed order
   assign key_lt = $signed(key_rdata) < $signed(key_ff);
   assign key_eq = (key_rdata == key_ff);

   assign rd_lvl   = (state_ff == S_LDAT) ? lvl_ff : i_ff;
   assign hdr_rd   = hdr_ff[rd_lvl];
   assign pred_rd  = pred_ff[i_ff];
   assign last_lvl = (HW'(i_ff) + HW'(1)) == h_ff;
   assign pop_idx  = fc_ff - CNTW'(1);
   assign hx       = {1'b0, req_node_height};

   // flat link address: node times levels plus level
   assign link_raddr = AW'(AW'(lr_node) * AW'(MAX_LEVELS) + AW'(lr_lvl));
   assign link_waddr = AW'(AW'(lw_node) * AW'(MAX_LEVELS) + AW'(lw_lvl));

   slom_ram #(.WIDTH(CW), .DEPTH(LD)) u_links (
      .clock(clock), .we(lk_we), .waddr(link_waddr), .wdata(lw_data),
      .raddr(link_raddr), .rdata(link_rdata));

   slom_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_keys (
      .clock(clock), .we(key_we), .waddr(node_w), .wdata(key_ff),
      .raddr(key_raddr), .rdata(key_rdata));

   slom_ram #(.WIDTH(64), .DEPTH(POOL_NODES)) u_values (
      .clock(clock), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
      .raddr(val_raddr), .rdata(val_rdata));

   slom_ram #(.WIDTH(HW), .DEPTH(POOL_NODES)) u_heights (
      .clock(clock), .we(ht_we), .waddr(node_w), .wdata(h_ff),
      .raddr(cand_ff[IW-1:0]), .rdata(ht_rdata));

   slom_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_free (
      .clock(clock), .we(stk_we), .waddr(stk_addr), .wdata(cand_ff[IW-1:0]),
      .raddr(stk_addr), .rdata(stk_rdata));

   // sequencer: next state, datapath next values and store controls
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      nxt_in        = nxt_ff;
      cand_in       = cand_ff;
      lvl_in        = lvl_ff;
      i_in          = i_ff;
      hops_in       = hops_ff;
      fc_in         = fc_ff;
      min_in        = min_ff;
      hit_in        = hit_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      hdr_we        = 1'b0;
      hdr_wd        = CW'(n_ff);
      pred_we       = 1'b0;
      lk_we         = 1'b0;
      lw_node       = n_ff;
      lw_lvl        = i_ff;
      lw_data       = NIL;
      lr_node       = x_ff[IW-1:0];
      lr_lvl        = lvl_ff;
      key_we        = 1'b0;
      key_raddr     = nxt_ff[IW-1:0];
      val_we        = 1'b0;
      val_waddr     = cand_ff[IW-1:0];
      val_wdata     = val_ff;
      val_raddr     = cand_ff[IW-1:0];
      ht_we         = 1'b0;
      stk_we        = 1'b0;
      stk_addr      = pop_idx[IW-1:0];
      node_w        = n_ff;
      got           = (pred_rd == HDR) ? hdr_rd : link_rdata;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_opcode;
               key_in = req_lookup_key;
               val_in = req_value_in;
               priority if (hx == 6'd0) begin
                  h_in = HW'(1);
               end else if (hx > 6'(MAX_LEVELS)) begin
                  h_in = HW'(MAX_LEVELS);
               end else begin
                  h_in = HW'(hx);
               end
               if (req_opcode == OP_UNUSED) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOTFOUND;
                  rsp_value_in  = '0;
               end else begin
                  x_in     = HDR;
                  lvl_in   = LVW'(MAX_LEVELS - 1);
                  hops_in  = '0;
                  state_in = S_LREQ;
               end
            end
         end
         S_LREQ: begin
            state_in = S_LDAT;
         end
         S_LDAT: begin
            nxt_in    = (x_ff == HDR) ? hdr_rd : link_rdata;
            key_raddr = nxt_in[IW-1:0];
            state_in  = S_KDAT;
         end
         S_KDAT: begin
            // advance along this level, drop one level, or finish at level zero
            if (nxt_ff < NIL && key_lt && hops_ff < CNTW'(POOL_NODES)) begin
               x_in     = nxt_ff;
               hops_in  = hops_ff + CNTW'(1);
               state_in = S_LREQ;
            end else begin
               pred_we = 1'b1;
               if (lvl_ff == '0) begin
                  cand_in  = nxt_ff;
                  hit_in   = (nxt_ff < NIL) && key_eq;
                  state_in = S_DISP;
               end else begin
                  lvl_in   = lvl_ff - LVW'(1);
                  hops_in  = '0;
                  state_in = S_LREQ;
               end
            end
         end
         S_DISP: begin
            i_in = '0;
            unique case (op_ff)
               OP_SEARCH: begin
                  if (hit_ff) begin
                     state_in = S_VDAT;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOTFOUND;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end
               end
               OP_INSERT: begin
                  priority if (hit_ff) begin
                     val_we        = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_UPDATED;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end else if (fc_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_FDAT;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     state_in = S_DHDAT;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOTFOUND;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_VDAT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FOUND;
            rsp_value_in  = val_rdata;
            state_in      = S_IDLE;
         end
         S_FDAT: begin
            // pop a free node; entries at or above the low-water mark were pushed
            if (pop_idx >= min_ff) begin
               n_in = stk_rdata;
            end else begin
               n_in = IW'(CNTW'(POOL_NODES - 1) - pop_idx);
            end
            node_w    = n_in;
            key_we    = 1'b1;
            val_we    = 1'b1;
            val_waddr = n_in;
            ht_we     = 1'b1;
            fc_in     = pop_idx;
            if (pop_idx < min_ff) begin
               min_in = pop_idx;
            end
            state_in = S_ILREQ;
         end
         S_ILREQ: begin
            lr_node  = pred_rd[IW-1:0];
            lr_lvl   = i_ff;
            state_in = S_ILDAT;
         end
         S_ILDAT: begin
            lk_we    = 1'b1;
            lw_data  = got;
            state_in = S_ISET;
         end
         S_ISET: begin
            // link the predecessor to the new node
            if (pred_rd == HDR) begin
               hdr_we = 1'b1;
               hdr_wd = CW'(n_ff);
            end else begin
               lk_we   = 1'b1;
               lw_node = pred_rd[IW-1:0];
               lw_data = CW'(n_ff);
            end
            if (last_lvl) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
            end else begin
               i_in     = i_ff + LVW'(1);
               state_in = S_ILREQ;
            end
         end
         S_DHDAT: begin
            h_in     = ht_rdata;
            state_in = S_DLREQ;
         end
         S_DLREQ: begin
            lr_node  = pred_rd[IW-1:0];
            lr_lvl   = i_ff;
            state_in = S_DLDAT;
         end
         S_DLDAT: begin
            state_in = (got == cand_ff) ? S_DCREQ : S_DCLR;
         end
         S_DCREQ: begin
            lr_node  = cand_ff[IW-1:0];
            lr_lvl   = i_ff;
            state_in = S_DCDAT;
         end
         S_DCDAT: begin
            // bypass the deleted node at this level
            if (pred_rd == HDR) begin
               hdr_we = 1'b1;
               hdr_wd = link_rdata;
            end else begin
               lk_we   = 1'b1;
               lw_node = pred_rd[IW-1:0];
               lw_data = link_rdata;
            end
            state_in = S_DCLR;
         end
         S_DCLR: begin
            lk_we   = 1'b1;
            lw_node = cand_ff[IW-1:0];
            lw_data = NIL;
            if (last_lvl) begin
               state_in = S_PUSH;
            end else begin
               i_in     = i_ff + LVW'(1);
               state_in = S_DLREQ;
            end
         end
         S_PUSH: begin
            // return the node to the free stack
            stk_addr = fc_ff[IW-1:0];
            if (fc_ff < CNTW'(POOL_NODES)) begin
               stk_we = 1'b1;
               fc_in  = fc_ff + CNTW'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FOUND;
            rsp_value_in  = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= CNTW'(POOL_NODES);
         min_ff       <= CNTW'(POOL_NODES);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_LEVELS; k++) begin
            hdr_ff[k]  <= NIL;
            pred_ff[k] <= HDR;
         end
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         if (hdr_we) begin
            hdr_ff[i_ff] <= hdr_wd;
         end
         if (pred_we) begin
            pred_ff[lvl_ff] <= x_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      nxt_ff        <= nxt_in;
      cand_ff       <= cand_in;
      lvl_ff        <= lvl_in;
      i_ff          <= i_in;
      hops_ff       <= hops_in;
      hit_ff        <= hit_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      h_ff          <= h_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

endmodule
